### design/mfb_pkg.sv
// Shared types, constants and helper functions of the monochrome frame-store raster engine.
`timescale 1ns / 1ps

package mfb_pkg;

    localparam int DEF_CANVAS_WIDTH = 384;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int CFG_W            = 11;
    localparam int COORD_W          = 16;
    localparam int DIAG_BIAS        = 1000;
    localparam int DIAG_BIAS_M6     = DIAG_BIAS % 6;
    localparam int RECIP6           = 10923;
    localparam int RECIP6_SHIFT     = 16;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [0:6][5:0] glyph_t;

    typedef enum logic [3:0] {
        OP_CLEAR   = 4'd0,
        OP_DOT     = 4'd1,
        OP_HLINE   = 4'd2,
        OP_VLINE   = 4'd3,
        OP_OUTLINE = 4'd4,
        OP_FILL    = 4'd5,
        OP_HATCH   = 4'd6,
        OP_RING    = 4'd7,
        OP_DISC    = 4'd8,
        OP_GLYPH   = 4'd9,
        OP_READ    = 4'd10
    } op_e;

    typedef enum logic [1:0] {
        K_SOLID,
        K_HATCH,
        K_CIRC,
        K_FULL
    } kind_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_INIT,
        ST_ROW,
        ST_CALC,
        ST_RD,
        ST_WR,
        ST_ADV,
        ST_DONE,
        ST_RR_ISSUE,
        ST_RR_OUT
    } state_e;

    function automatic logic [2:0] mod6_wide(input logic [12:0] v);
        logic [26:0] p;
        logic [12:0] q;
        logic [15:0] rem;
        p   = 27'(v) * 27'(RECIP6);
        q   = 13'(p >> RECIP6_SHIFT);
        rem = 16'(v) - 16'(q) * 16'(6);
        if (rem >= 16'(6)) begin
            rem = rem - 16'(6);
        end
        return 3'(rem);
    endfunction

    function automatic logic [2:0] mod6_small(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd12) begin
            r = v - 5'd12;
        end else if (v >= 5'd6) begin
            r = v - 5'd6;
        end else begin
            r = v;
        end
        return 3'(r);
    endfunction

    function automatic logic [2:0] mod3_small(input logic [2:0] v);
        return (v >= 3'd3) ? v - 3'd3 : v;
    endfunction

    function automatic glyph_t glyph_rows(input logic [7:0] code_in);
        logic [7:0] c;
        glyph_t g;
        c = code_in;
        if (c >= "a" && c <= "z") begin
            c = c - 8'd32;
        end
        case (c)
            "0": g = {6'h1E,6'h21,6'h21,6'h21,6'h21,6'h21,6'h1E};
            "1": g = {6'h08,6'h18,6'h28,6'h08,6'h08,6'h08,6'h3E};
            "2": g = {6'h1E,6'h21,6'h01,6'h0E,6'h18,6'h20,6'h3F};
            "3": g = {6'h1E,6'h21,6'h01,6'h0E,6'h01,6'h21,6'h1E};
            "4": g = {6'h02,6'h06,6'h0A,6'h12,6'h3F,6'h02,6'h02};
            "5": g = {6'h3F,6'h20,6'h3E,6'h01,6'h01,6'h21,6'h1E};
            "6": g = {6'h1E,6'h21,6'h20,6'h3E,6'h21,6'h21,6'h1E};
            "7": g = {6'h3F,6'h01,6'h02,6'h04,6'h08,6'h10,6'h10};
            "8": g = {6'h1E,6'h21,6'h21,6'h1E,6'h21,6'h21,6'h1E};
            "9": g = {6'h1E,6'h21,6'h21,6'h1F,6'h01,6'h21,6'h1E};
            "A": g = {6'h0C,6'h12,6'h21,6'h3F,6'h21,6'h21,6'h21};
            "B": g = {6'h3E,6'h21,6'h21,6'h3E,6'h21,6'h21,6'h3E};
            "C": g = {6'h1E,6'h21,6'h20,6'h20,6'h20,6'h21,6'h1E};
            "D": g = {6'h3C,6'h22,6'h21,6'h21,6'h21,6'h22,6'h3C};
            "E": g = {6'h3F,6'h20,6'h20,6'h3E,6'h20,6'h20,6'h3F};
            "F": g = {6'h3F,6'h20,6'h20,6'h3E,6'h20,6'h20,6'h20};
            "G": g = {6'h1E,6'h21,6'h20,6'h27,6'h21,6'h21,6'h1E};
            "H": g = {6'h21,6'h21,6'h21,6'h3F,6'h21,6'h21,6'h21};
            "I": g = {6'h1F,6'h04,6'h04,6'h04,6'h04,6'h04,6'h1F};
            "J": g = {6'h07,6'h02,6'h02,6'h02,6'h22,6'h22,6'h1C};
            "K": g = {6'h21,6'h22,6'h24,6'h38,6'h24,6'h22,6'h21};
            "L": g = {6'h20,6'h20,6'h20,6'h20,6'h20,6'h20,6'h3F};
            "M": g = {6'h21,6'h33,6'h2D,6'h21,6'h21,6'h21,6'h21};
            "N": g = {6'h21,6'h31,6'h29,6'h25,6'h23,6'h21,6'h21};
            "O": g = {6'h1E,6'h21,6'h21,6'h21,6'h21,6'h21,6'h1E};
            "P": g = {6'h3E,6'h21,6'h21,6'h3E,6'h20,6'h20,6'h20};
            "Q": g = {6'h1E,6'h21,6'h21,6'h21,6'h25,6'h22,6'h1D};
            "R": g = {6'h3E,6'h21,6'h21,6'h3E,6'h24,6'h22,6'h21};
            "S": g = {6'h1E,6'h21,6'h20,6'h1E,6'h01,6'h21,6'h1E};
            "T": g = {6'h3F,6'h04,6'h04,6'h04,6'h04,6'h04,6'h04};
            "U": g = {6'h21,6'h21,6'h21,6'h21,6'h21,6'h21,6'h1E};
            "V": g = {6'h21,6'h21,6'h21,6'h12,6'h12,6'h0C,6'h0C};
            "W": g = {6'h21,6'h21,6'h21,6'h21,6'h2D,6'h33,6'h21};
            "X": g = {6'h21,6'h12,6'h0C,6'h0C,6'h12,6'h21,6'h21};
            "Y": g = {6'h21,6'h12,6'h0C,6'h04,6'h04,6'h04,6'h04};
            "Z": g = {6'h3F,6'h02,6'h04,6'h08,6'h10,6'h20,6'h3F};
            ".": g = {6'h00,6'h00,6'h00,6'h00,6'h00,6'h0C,6'h0C};
            ":": g = {6'h00,6'h0C,6'h0C,6'h00,6'h0C,6'h0C,6'h00};
            "-": g = {6'h00,6'h00,6'h00,6'h3E,6'h00,6'h00,6'h00};
            "+": g = {6'h00,6'h08,6'h08,6'h3E,6'h08,6'h08,6'h00};
            "=": g = {6'h00,6'h3E,6'h00,6'h3E,6'h00,6'h00,6'h00};
            "*": g = {6'h00,6'h2A,6'h1C,6'h3E,6'h1C,6'h2A,6'h00};
            "/": g = {6'h01,6'h02,6'h04,6'h08,6'h10,6'h20,6'h00};
            "(": g = {6'h04,6'h08,6'h10,6'h10,6'h10,6'h08,6'h04};
            ")": g = {6'h10,6'h08,6'h04,6'h04,6'h04,6'h08,6'h10};
            "?": g = {6'h1E,6'h21,6'h02,6'h04,6'h04,6'h00,6'h04};
            "!": g = {6'h04,6'h04,6'h04,6'h04,6'h04,6'h00,6'h04};
            "[": g = {6'h1E,6'h10,6'h10,6'h10,6'h10,6'h10,6'h1E};
            "]": g = {6'h1E,6'h02,6'h02,6'h02,6'h02,6'h02,6'h1E};
            "_": g = {6'h00,6'h00,6'h00,6'h00,6'h00,6'h00,6'h3F};
            ",": g = {6'h00,6'h00,6'h00,6'h00,6'h0C,6'h04,6'h08};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### design/mono_framebuffer_raster_engine.sv
// Top level of the monochrome frame-store raster engine with its byte-wide frame memory.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Moves
// s_        in         s_valid, s_ready, s_<field>             one drawing command
// m_        out        m_valid, m_ready, m_data, m_last        one result byte
// cfg_      in         cfg_valid, cfg_ready, cfg_canvas_height canvas height write
//
// Drawing works on one frame byte at a time: each touched byte takes an operand set-up,
// a memory read and a memory write, plus a row step per row and set-up and advance steps per band or glyph cell.
// Read row reads each byte and then sends it, waiting while the output register is full.
// Reset clears the height to zero; a height write then clears height * ROW_BYTES bytes
// through the same byte loop before the next command is taken.
// A stalled result transfer holds the engine only when the next result is ready.

module mono_framebuffer_raster_engine
    import mfb_pkg::*;
#(
    parameter int CANVAS_WIDTH = DEF_CANVAS_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_canvas_height,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_operation,
    input  logic signed [12:0]  s_pos_x,
    input  logic signed [12:0]  s_pos_y,
    input  logic signed [12:0]  s_size_w,
    input  logic signed [12:0]  s_size_h,
    input  logic signed [11:0]  s_radius,
    input  logic [7:0]          s_thickness,
    input  logic                s_color,
    input  logic [7:0]          s_pattern,
    input  logic [7:0]          s_char_code,
    input  logic [7:0]          s_scale,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_data,
    output logic                m_last
);

    localparam int ROW_BYTES = (CANVAS_WIDTH + 7) / 8;
    localparam int DEPTH     = ROW_BYTES * MAX_HEIGHT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BYW       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int XW        = $clog2(CANVAS_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam coord_t W_C   = coord_t'(CANVAS_WIDTH);

    logic [7:0] frame_mem [DEPTH];
    logic [7:0] mem_q_reg;
    logic       mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [7:0] mem_wdata;

    state_e state_reg, state_next;
    logic [HW-1:0] hgt_reg, hgt_next;
    logic [3:0] op_reg, op_next;
    coord_t x_reg, x_next, y_reg, y_next, w_reg, w_next, h_reg, h_next;
    coord_t r_reg, r_next, t_reg, t_next;
    logic c_reg, c_next;
    logic [2:0] pat_reg, pat_next;
    logic [7:0] code_reg, code_next, sc_reg, sc_next;
    logic cfgclr_reg, cfgclr_next;
    logic [1:0] pidx_reg, pidx_next;
    logic [2:0] gr_reg, gr_next, gk_reg, gk_next;
    coord_t gx_reg, gx_next, gy_reg, gy_next;
    kind_e kind_reg, kind_next;
    logic pc_reg, pc_next;
    logic [XW-1:0] cl_reg, cl_next, cr_reg, cr_next;
    logic [HW-1:0] row_reg, row_next, rb_reg, rb_next;
    logic [BYW-1:0] byte_reg, byte_next, bfirst_reg, bfirst_next, blast_reg, blast_next;
    logic [AW-1:0] rowbase_reg, rowbase_next;
    logic [2:0] ym6_reg, ym6_next, bm6_reg, bm6_next, bm6f_reg, bm6f_next;
    logic [1:0] ym4_reg, ym4_next;
    logic signed [31:0] osq_reg, osq_next, isq_reg, isq_next;
    logic signed [31:0] dy2_reg, dy2_next, dx2_reg, dx2_next;
    coord_t dx_reg, dx_next;
    logic rdok_reg, rdok_next;
    logic m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [7:0] m_data_reg, m_data_next;

    glyph_t gl;
    logic out_free;
    logic [7:0] mask;
    logic en_d;
    coord_t x0, x1, y0, y1, hgt_c, cl_c, cr_c, rt_c, rb_c, crm1, y_in;
    kind_e kind_d;
    logic col_d;
    int dxi, dyi, rti;

    assign gl        = glyph_rows(code_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign hgt_c     = coord_t'(hgt_reg);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign m_last    = m_last_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= frame_mem[mem_raddr];
        end
    end

    // Band descriptor of the current primitive pass and its clipped extent.
    always_comb begin
        en_d   = 1'b0;
        x0     = x_reg;
        x1     = x_reg;
        y0     = y_reg;
        y1     = y_reg;
        kind_d = K_SOLID;
        col_d  = c_reg;
        unique case (op_reg)
            OP_CLEAR: begin
                en_d = 1'b1; x0 = '0; x1 = W_C; y0 = '0; y1 = hgt_c; kind_d = K_FULL;
            end
            OP_DOT: begin
                en_d = 1'b1; x1 = x_reg + coord_t'(1); y1 = y_reg + coord_t'(1);
            end
            OP_HLINE: begin
                en_d = (w_reg > 0); x1 = x_reg + w_reg; y1 = y_reg + t_reg;
            end
            OP_VLINE: begin
                en_d = (h_reg > 0); x1 = x_reg + t_reg; y1 = y_reg + h_reg;
            end
            OP_OUTLINE: begin
                en_d = (w_reg > 0) && (h_reg > 0);
                case (pidx_reg)
                    2'd0: begin
                        x1 = x_reg + w_reg; y1 = y_reg + t_reg;
                    end
                    2'd1: begin
                        x1 = x_reg + w_reg; y0 = y_reg + h_reg - t_reg; y1 = y_reg + h_reg;
                    end
                    2'd2: begin
                        x1 = x_reg + t_reg; y1 = y_reg + h_reg;
                    end
                    default: begin
                        x0 = x_reg + w_reg - t_reg; x1 = x_reg + w_reg; y1 = y_reg + h_reg;
                    end
                endcase
            end
            OP_FILL: begin
                en_d = (w_reg > 0) && (h_reg > 0); x1 = x_reg + w_reg; y1 = y_reg + h_reg;
            end
            OP_HATCH: begin
                en_d = (w_reg > 0) && (h_reg > 0); x1 = x_reg + w_reg; y1 = y_reg + h_reg;
                kind_d = K_HATCH; col_d = 1'b1;
            end
            OP_RING, OP_DISC: begin
                en_d = (r_reg > 0);
                x0 = x_reg - r_reg; x1 = x_reg + r_reg + coord_t'(1);
                y0 = y_reg - r_reg; y1 = y_reg + r_reg + coord_t'(1);
                kind_d = K_CIRC;
            end
            OP_GLYPH: begin
                en_d = (sc_reg != 8'd0) && gl[gr_reg][3'd5 - gk_reg];
                x0 = gx_reg; x1 = gx_reg + coord_t'(sc_reg);
                y0 = gy_reg; y1 = gy_reg + coord_t'(sc_reg);
            end
            default: begin
                en_d = 1'b0;
            end
        endcase
        cl_c = (x0 < 0) ? coord_t'(0) : ((x0 > W_C) ? W_C : x0);
        cr_c = (x1 > W_C) ? W_C : ((x1 < 0) ? coord_t'(0) : x1);
        rt_c = (y0 < 0) ? coord_t'(0) : ((y0 > hgt_c) ? hgt_c : y0);
        rb_c = (y1 > hgt_c) ? hgt_c : ((y1 < 0) ? coord_t'(0) : y1);
        crm1 = cr_c - coord_t'(1);
    end

    // Dot mask of the current byte.
    always_comb begin
        mask = '0;
        for (int k = 0; k < 8; k++) begin : g_dot
            logic [15:0] pxu;
            logic in_box, hit;
            logic [2:0] pm6, s6, d6, pm3, ym3, s3, d3;
            logic [1:0] k2;
            int qk;
            pxu = 16'({byte_reg, 3'b000}) + 16'(k);
            in_box = (pxu >= 16'(cl_reg)) && (pxu < 16'(cr_reg));
            pm6 = mod6_small(5'(bm6_reg) + 5'(k));
            s6  = mod6_small(5'(pm6) + 5'(ym6_reg));
            d6  = mod6_small(5'(pm6) + 5'(DIAG_BIAS_M6 + 6) - 5'(ym6_reg));
            pm3 = mod3_small(pm6);
            ym3 = mod3_small(ym6_reg);
            s3  = mod3_small(s6);
            d3  = mod3_small(d6);
            k2  = 2'(k);
            case (pat_reg)
                3'd1: hit = (s6 == 3'd0);
                3'd2: hit = (d6 == 3'd0);
                3'd3: hit = (k2 == 2'd0) || (ym4_reg == 2'd0);
                3'd4: hit = ((k2 + ym4_reg) == 2'd0);
                3'd5: hit = (pm3 == 3'd0) && (ym3 == 3'd0);
                3'd6: hit = (s3 == 3'd0) || (d3 == 3'd0);
                3'd7: hit = (ym3 == 3'd0);
                default: hit = 1'b0;
            endcase
            qk = int'(dx2_reg) + int'(dy2_reg) + 2 * k * int'(dx_reg) + k * k;
            case (kind_reg)
                K_FULL:  mask[7-k] = 1'b1;
                K_HATCH: mask[7-k] = in_box && hit;
                K_CIRC:  mask[7-k] = in_box && (qk >= int'(isq_reg)) && (qk <= int'(osq_reg));
                default: mask[7-k] = in_box;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        hgt_next     = hgt_reg;
        op_next      = op_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        r_next       = r_reg;
        t_next       = t_reg;
        c_next       = c_reg;
        pat_next     = pat_reg;
        code_next    = code_reg;
        sc_next      = sc_reg;
        cfgclr_next  = cfgclr_reg;
        pidx_next    = pidx_reg;
        gr_next      = gr_reg;
        gk_next      = gk_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        kind_next    = kind_reg;
        pc_next      = pc_reg;
        cl_next      = cl_reg;
        cr_next      = cr_reg;
        row_next     = row_reg;
        rb_next      = rb_reg;
        byte_next    = byte_reg;
        bfirst_next  = bfirst_reg;
        blast_next   = blast_reg;
        rowbase_next = rowbase_reg;
        ym6_next     = ym6_reg;
        bm6_next     = bm6_reg;
        bm6f_next    = bm6f_reg;
        ym4_next     = ym4_reg;
        osq_next     = osq_reg;
        isq_next     = isq_reg;
        dy2_next     = dy2_reg;
        dx2_next     = dx2_reg;
        dx_next      = dx_reg;
        rdok_next    = rdok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_raddr    = rowbase_reg + AW'(byte_reg);
        mem_waddr    = rowbase_reg + AW'(byte_reg);
        mem_wdata    = (mem_q_reg & ~mask) | (pc_reg ? mask : 8'h00);
        y_in         = coord_t'(s_pos_y);
        dxi          = int'({byte_reg, 3'b000}) - int'(x_reg);
        dyi          = int'(row_reg) - int'(y_reg);
        rti          = int'(r_reg) - int'(t_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    hgt_next = (32'(cfg_canvas_height) > 32'(MAX_HEIGHT)) ?
                               HW'(MAX_HEIGHT) : HW'(cfg_canvas_height);
                    cfgclr_next = 1'b1;
                    op_next = OP_CLEAR;
                    c_next = 1'b0;
                    state_next = ST_PREP;
                end else if (s_valid) begin
                    op_next = s_operation;
                    x_next = coord_t'(s_pos_x);
                    y_next = y_in;
                    w_next = coord_t'(s_size_w);
                    h_next = coord_t'(s_size_h);
                    r_next = coord_t'(s_radius);
                    t_next = coord_t'(s_thickness);
                    c_next = s_color;
                    pat_next = s_pattern[2:0];
                    code_next = s_char_code;
                    sc_next = s_scale;
                    pidx_next = '0;
                    gr_next = '0;
                    gk_next = '0;
                    gx_next = coord_t'(s_pos_x);
                    gy_next = y_in;
                    byte_next = '0;
                    rdok_next = (y_in >= 0) && (y_in < hgt_c);
                    rowbase_next = ((y_in >= 0) && (y_in < hgt_c)) ?
                                   AW'(int'(y_in) * ROW_BYTES) : '0;
                    state_next = (s_operation == OP_READ) ? ST_RR_ISSUE : ST_PREP;
                end
            end
            ST_PREP: begin
                kind_next = kind_d;
                pc_next = col_d;
                cl_next = XW'(cl_c);
                cr_next = XW'(cr_c);
                row_next = HW'(rt_c);
                rb_next = HW'(rb_c);
                bfirst_next = cl_c[BYW+2:3];
                blast_next = crm1[BYW+2:3];
                rowbase_next = AW'(int'(rt_c) * ROW_BYTES);
                osq_next = int'(r_reg) * int'(r_reg);
                if (en_d && (cl_c < cr_c) && (rt_c < rb_c)) begin
                    state_next = ST_INIT;
                end else begin
                    state_next = ST_ADV;
                end
            end
            ST_INIT: begin
                ym6_next = mod6_wide(13'(row_reg));
                ym4_next = 2'(row_reg);
                bm6f_next = mod6_wide(13'({bfirst_reg, 3'b000}));
                isq_next = ((op_reg == OP_RING) && (r_reg >= t_reg)) ? rti * rti : 0;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                dy2_next = dyi * dyi;
                bm6_next = bm6f_reg;
                byte_next = bfirst_reg;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                dx2_next = dxi * dxi;
                dx_next = coord_t'(dxi);
                state_next = ST_RD;
            end
            ST_RD: begin
                mem_re = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                mem_we = 1'b1;
                if (byte_reg == blast_reg) begin
                    if ((row_reg + HW'(1)) == rb_reg) begin
                        state_next = ST_ADV;
                    end else begin
                        row_next = row_reg + HW'(1);
                        rowbase_next = rowbase_reg + AW'(ROW_BYTES);
                        ym6_next = (ym6_reg == 3'd5) ? 3'd0 : ym6_reg + 3'd1;
                        ym4_next = ym4_reg + 2'd1;
                        state_next = ST_ROW;
                    end
                end else begin
                    byte_next = byte_reg + BYW'(1);
                    bm6_next = mod6_small(5'(bm6_reg) + 5'd2);
                    state_next = ST_CALC;
                end
            end
            ST_ADV: begin
                state_next = ST_DONE;
                if (op_reg == OP_OUTLINE && pidx_reg != 2'd3) begin
                    pidx_next = pidx_reg + 2'd1;
                    state_next = ST_PREP;
                end else if (op_reg == OP_GLYPH && !(gr_reg == 3'd6 && gk_reg == 3'd5)) begin
                    if (gk_reg == 3'd5) begin
                        gk_next = '0;
                        gx_next = x_reg;
                        gr_next = gr_reg + 3'd1;
                        gy_next = gy_reg + coord_t'(sc_reg);
                    end else begin
                        gk_next = gk_reg + 3'd1;
                        gx_next = gx_reg + coord_t'(sc_reg);
                    end
                    state_next = ST_PREP;
                end
            end
            ST_DONE: begin
                if (cfgclr_reg) begin
                    cfgclr_next = 1'b0;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = 8'h00;
                    m_last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RR_ISSUE: begin
                mem_re = 1'b1;
                state_next = ST_RR_OUT;
            end
            ST_RR_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = rdok_reg ? mem_q_reg : 8'h00;
                    m_last_next = (int'(byte_reg) == ROW_BYTES - 1);
                    if (int'(byte_reg) == ROW_BYTES - 1) begin
                        state_next = ST_IDLE;
                    end else begin
                        byte_next = byte_reg + BYW'(1);
                        state_next = ST_RR_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hgt_reg     <= '0;
            cfgclr_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hgt_reg     <= hgt_next;
            cfgclr_reg  <= cfgclr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        r_reg       <= r_next;
        t_reg       <= t_next;
        c_reg       <= c_next;
        pat_reg     <= pat_next;
        code_reg    <= code_next;
        sc_reg      <= sc_next;
        pidx_reg    <= pidx_next;
        gr_reg      <= gr_next;
        gk_reg      <= gk_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        kind_reg    <= kind_next;
        pc_reg      <= pc_next;
        cl_reg      <= cl_next;
        cr_reg      <= cr_next;
        row_reg     <= row_next;
        rb_reg      <= rb_next;
        byte_reg    <= byte_next;
        bfirst_reg  <= bfirst_next;
        blast_reg   <= blast_next;
        rowbase_reg <= rowbase_next;
        ym6_reg     <= ym6_next;
        bm6_reg     <= bm6_next;
        bm6f_reg    <= bm6f_next;
        ym4_reg     <= ym4_next;
        osq_reg     <= osq_next;
        isq_reg     <= isq_next;
        dy2_reg     <= dy2_next;
        dx2_reg     <= dx2_next;
        dx_reg      <= dx_next;
        rdok_reg    <= rdok_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WR |-> $past(state_reg) == ST_RD)
        else $error("Frame write without a preceding read of the same byte.");

    a_rd_after_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> $past(state_reg) == ST_CALC)
        else $error("Frame read without operand set-up.");

    a_wr_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WR |-> (row_reg < hgt_reg) && (int'(byte_reg) < ROW_BYTES))
        else $error("Frame write outside the canvas.");

    a_cfg_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_ready && s_valid && s_ready))
        else $error("Height write and command transfer in the same cycle.");

endmodule
